/* rtl/rgbc_pkg.sv */
// Shared types and constants for the 3x3 RGB convolution block.
package rgbc_pkg;

    localparam int PIXEL_W    = 24;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int NUM_TAPS   = 9;
    localparam int KEEP_W     = 4;
    localparam int COEF_W     = 8;
    localparam int PROD_W     = 17;
    localparam int SUM_W      = 20;
    localparam int DCNT_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam int ROW_STRIDE_DEF = 100;
    localparam int LINE_DEPTH_DEF = 203;

    localparam logic [CFG_IDX_W-1:0] CFG_COEFFS_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_LAST    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DIVISOR = 2'd2;

    localparam logic signed [COEF_W-1:0] SCALE_RESET = 8'sd1;
    localparam logic [CH_W-1:0]          CH_MAX      = 8'hFF;

    typedef logic [PIXEL_W-1:0] t_pixel;
    typedef logic signed [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic [KEEP_W-1:0] keep;
        logic [KEEP_W-1:0] strobe;
        logic              last;
        logic              dest;
        logic              id;
        logic              user;
    } t_side;

endpackage

/* rtl/rgbc_ifs.sv */
// Stream and configuration channel interfaces of the convolution block.
interface rgbc_in_if;
    logic                               valid;
    logic                               ready;
    logic [rgbc_pkg::PIXEL_W-1:0]       pixel_in;
    logic [rgbc_pkg::KEEP_W-1:0]        keep_in;
    logic [rgbc_pkg::KEEP_W-1:0]        strobe_in;
    logic                               last_in;
    logic                               dest_in;
    logic                               id_in;
    logic                               user_in;

    modport source (output valid, pixel_in, keep_in, strobe_in, last_in, dest_in, id_in,
                    user_in, input ready);
    modport sink (input valid, pixel_in, keep_in, strobe_in, last_in, dest_in, id_in,
                  user_in, output ready);
endinterface

interface rgbc_out_if;
    logic                               valid;
    logic                               ready;
    logic [rgbc_pkg::PIXEL_W-1:0]       pixel_out;
    logic [rgbc_pkg::KEEP_W-1:0]        keep_out;
    logic [rgbc_pkg::KEEP_W-1:0]        strobe_out;
    logic                               last_out;
    logic                               dest_out;
    logic                               id_out;
    logic                               user_out;

    modport source (output valid, pixel_out, keep_out, strobe_out, last_out, dest_out,
                    id_out, user_out, input ready);
    modport sink (input valid, pixel_out, keep_out, strobe_out, last_out, dest_out,
                  id_out, user_out, output ready);
endinterface

interface rgbc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [rgbc_pkg::CFG_IDX_W-1:0]      index;
    logic [rgbc_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/rgbc_cell.sv */
// One stage of the pixel delay line.
module rgbc_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  rgbc_pkg::t_pixel i_d,
    output rgbc_pkg::t_pixel o_q
);

    rgbc_pkg::t_pixel r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

/* rtl/rgbc_line.sv */
// Pixel delay line built from a chain of cells, with the nine window taps.
module rgbc_line #(
    parameter int ROW_STRIDE = rgbc_pkg::ROW_STRIDE_DEF,
    parameter int LINE_DEPTH = rgbc_pkg::LINE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  rgbc_pkg::t_pixel i_pixel,
    output rgbc_pkg::t_pixel o_taps [rgbc_pkg::NUM_TAPS]
);

    rgbc_pkg::t_pixel w_q [LINE_DEPTH];

    // The newest pixel enters the top cell; cell 0 holds the oldest one.
    for (genvar i = 0; i < LINE_DEPTH; i++) begin : g_cell
        if (i == LINE_DEPTH - 1) begin : g_top
            rgbc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_shift),
                .i_d     (i_pixel),
                .o_q     (w_q[i])
            );
        end else begin : g_mid
            rgbc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_shift),
                .i_d     (w_q[i+1]),
                .o_q     (w_q[i])
            );
        end
    end

    // A tap that falls past the end of the line reads as a black pixel.
    for (genvar t = 0; t < rgbc_pkg::NUM_TAPS; t++) begin : g_tap
        localparam int TapIdx = (t / 3) * ROW_STRIDE + (t % 3);
        if (TapIdx < LINE_DEPTH) begin : g_in
            assign o_taps[t] = w_q[TapIdx];
        end else begin : g_out
            assign o_taps[t] = '0;
        end
    end

endmodule

/* rtl/rgbc_div.sv */
// Bit-serial signed divider with truncation toward zero and clamp to 0..255.
module rgbc_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  rgbc_pkg::t_sum                   i_dividend,
    input  logic signed [rgbc_pkg::COEF_W-1:0] i_divisor,
    output logic                             o_done,
    output logic [rgbc_pkg::CH_W-1:0]        o_result
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIN
    } t_dstate;

    t_dstate                         r_state;
    logic [rgbc_pkg::SUM_W-1:0]      r_quo;
    logic [rgbc_pkg::COEF_W-1:0]     r_rem;
    logic [rgbc_pkg::COEF_W-1:0]     r_dmag;
    logic                            r_qneg;
    logic [rgbc_pkg::DCNT_W-1:0]     r_cnt;

    logic [rgbc_pkg::SUM_W-1:0]      w_mag;
    logic [rgbc_pkg::COEF_W-1:0]     w_dmag;
    logic [rgbc_pkg::COEF_W:0]       w_trial;
    logic                            w_fits;

    always_comb begin
        w_mag   = i_dividend[rgbc_pkg::SUM_W-1] ? rgbc_pkg::SUM_W'(-i_dividend)
                                                : rgbc_pkg::SUM_W'(i_dividend);
        w_dmag  = i_divisor[rgbc_pkg::COEF_W-1] ? rgbc_pkg::COEF_W'(-i_divisor)
                                                : rgbc_pkg::COEF_W'(i_divisor);
        w_trial = {r_rem, r_quo[rgbc_pkg::SUM_W-1]};
        w_fits  = (w_trial >= {1'b0, r_dmag});
    end

    // Restoring division on magnitudes: the dividend shifts out of the top of
    // r_quo while quotient bits shift in at the bottom.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_quo  <= w_mag;
                        r_rem  <= '0;
                        r_dmag <= w_dmag;
                        r_cnt  <= '0;
                        r_qneg <= i_dividend[rgbc_pkg::SUM_W-1]
                                  ^ i_divisor[rgbc_pkg::COEF_W-1];
                        // A zero divisor passes the sum through undivided.
                        r_state <= (i_divisor == '0) ? D_FIN : D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= w_fits ? rgbc_pkg::COEF_W'(w_trial - {1'b0, r_dmag})
                                    : rgbc_pkg::COEF_W'(w_trial);
                    r_quo <= {r_quo[rgbc_pkg::SUM_W-2:0], w_fits};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == rgbc_pkg::DCNT_W'(rgbc_pkg::SUM_W - 1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == D_FIN);

    always_comb begin
        if (r_qneg && (r_quo != '0)) begin
            o_result = '0;
        end else if (r_quo > rgbc_pkg::SUM_W'(rgbc_pkg::CH_MAX)) begin
            o_result = rgbc_pkg::CH_MAX;
        end else begin
            o_result = r_quo[rgbc_pkg::CH_W-1:0];
        end
    end

endmodule

/* rtl/rgb_conv3x3_stream_top.sv */
// Top level of the streaming 3x3 RGB convolution block.
// Each accepted pixel word shifts into a delay line of LINE_DEPTH cells; the
// 3x3 window is read at offsets 0..2, ROW_STRIDE..ROW_STRIDE+2 and
// 2*ROW_STRIDE..2*ROW_STRIDE+2, multiplied by nine signed coefficients that
// all three channels share, summed, divided by the signed scale (truncating
// toward zero, or not at all when the scale is zero) and clamped to 0..255.
// One item is in work at a time: the result word is loaded into the output
// register once the divider, producing one of 20 quotient bits per cycle,
// is done (the division is skipped when the scale is zero) and the output
// register is empty or being taken, and the input is ready again on the
// following cycle even while that word still waits to be taken.
// Configuration writes are always accepted and are meant for when the block is idle.
module rgb_conv3x3_stream_top #(
    parameter int ROW_STRIDE = rgbc_pkg::ROW_STRIDE_DEF,
    parameter int LINE_DEPTH = rgbc_pkg::LINE_DEPTH_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    rgbc_in_if.sink    i_pix,
    rgbc_out_if.source o_pix,
    rgbc_cfg_if.sink   i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_START,
        S_DIV,
        S_HOLD
    } t_state;

    t_state                                  r_state;
    logic                                    r_out_valid;
    rgbc_pkg::t_pixel                        r_pixel_out;
    rgbc_pkg::t_side                         r_side;
    rgbc_pkg::t_side                         r_out_side;

    logic [rgbc_pkg::CFG_DATA_W-1:0]         r_coeffs_low;
    logic signed [rgbc_pkg::COEF_W-1:0]      r_coeff_last;
    logic signed [rgbc_pkg::COEF_W-1:0]      r_scale;

    logic signed [rgbc_pkg::PROD_W-1:0]      r_prod [rgbc_pkg::NUM_CH][rgbc_pkg::NUM_TAPS];
    rgbc_pkg::t_sum                          r_sum  [rgbc_pkg::NUM_CH];
    rgbc_pkg::t_sum                          n_sum  [rgbc_pkg::NUM_CH];

    logic                                    w_accept;
    logic                                    w_load;
    rgbc_pkg::t_pixel                        w_taps [rgbc_pkg::NUM_TAPS];
    logic signed [rgbc_pkg::COEF_W-1:0]      w_coef [rgbc_pkg::NUM_TAPS];
    logic [rgbc_pkg::NUM_CH-1:0]             w_done;
    logic [rgbc_pkg::CH_W-1:0]               w_res  [rgbc_pkg::NUM_CH];

    assign i_pix.ready = (r_state == S_IDLE);
    assign w_accept    = i_pix.valid && (r_state == S_IDLE);
    assign w_load      = (r_state == S_HOLD) && (!r_out_valid || o_pix.ready);

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs_low <= '0;
            r_coeff_last <= '0;
            r_scale      <= rgbc_pkg::SCALE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                rgbc_pkg::CFG_COEFFS_LOW:    r_coeffs_low <= i_cfg.data;
                rgbc_pkg::CFG_COEFF_LAST:    r_coeff_last <= i_cfg.data[rgbc_pkg::COEF_W-1:0];
                rgbc_pkg::CFG_SCALE_DIVISOR: r_scale <= i_cfg.data[rgbc_pkg::COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rgbc_line #(
        .ROW_STRIDE (ROW_STRIDE),
        .LINE_DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_accept),
        .i_pixel (i_pix.pixel_in),
        .o_taps  (w_taps)
    );

    always_comb begin
        for (int t = 0; t < rgbc_pkg::NUM_TAPS - 1; t++) begin
            w_coef[t] = r_coeffs_low[rgbc_pkg::COEF_W*t +: rgbc_pkg::COEF_W];
        end
        w_coef[rgbc_pkg::NUM_TAPS-1] = r_coeff_last;
    end

    // Products are registered, then summed per channel in the next cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            for (int c = 0; c < rgbc_pkg::NUM_CH; c++) begin
                for (int t = 0; t < rgbc_pkg::NUM_TAPS; t++) begin
                    r_prod[c][t] <= rgbc_pkg::PROD_W'($signed({1'b0,
                                        w_taps[t][rgbc_pkg::CH_W*c +: rgbc_pkg::CH_W]}))
                                    * rgbc_pkg::PROD_W'(w_coef[t]);
                end
            end
        end
        if (r_state == S_SUM) begin
            for (int c = 0; c < rgbc_pkg::NUM_CH; c++) begin
                r_sum[c] <= n_sum[c];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < rgbc_pkg::NUM_CH; c++) begin
            n_sum[c] = '0;
            for (int t = 0; t < rgbc_pkg::NUM_TAPS; t++) begin
                n_sum[c] = n_sum[c] + rgbc_pkg::SUM_W'(r_prod[c][t]);
            end
        end
    end

    for (genvar c = 0; c < rgbc_pkg::NUM_CH; c++) begin : g_div
        rgbc_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (r_state == S_START),
            .i_dividend (r_sum[c]),
            .i_divisor  (r_scale),
            .o_done     (w_done[c]),
            .o_result   (w_res[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_side  <= '{keep: i_pix.keep_in, strobe: i_pix.strobe_in,
                                     last: i_pix.last_in, dest: i_pix.dest_in,
                                     id: i_pix.id_in, user: i_pix.user_in};
                        r_state <= S_MUL;
                    end
                end
                S_MUL:   r_state <= S_SUM;
                S_SUM:   r_state <= S_START;
                S_START: r_state <= S_DIV;
                S_DIV: begin
                    if (&w_done) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_load) begin
                r_out_valid <= 1'b1;
                r_pixel_out <= {w_res[2], w_res[1], w_res[0]};
                r_out_side  <= r_side;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_out  = r_pixel_out;
    assign o_pix.keep_out   = r_out_side.keep;
    assign o_pix.strobe_out = r_out_side.strobe;
    assign o_pix.last_out   = r_out_side.last;
    assign o_pix.dest_out   = r_out_side.dest;
    assign o_pix.id_out     = r_out_side.id;
    assign o_pix.user_out   = r_out_side.user;

endmodule
